[rtl/msp_pkg.sv]
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the motor speed PID/PWM block
// Payload structs for the request and response channels, register indexes,
// field widths and register reset values.
// ----------------------------------------------------------------------------
package msp_pkg;

   // Field widths fixed by the interface.
   localparam int SPEED_BITS     = 16;
   localparam int GAIN_BITS      = 24;
   localparam int INTEG_BITS     = 48;
   localparam int PWM_BITS       = 8;
   localparam int PWM_MAX        = 255;
   localparam int CSR_INDEX_BITS = 2;

   // Register reset values.
   localparam logic signed [GAIN_BITS-1:0] GAIN_P_RESET  = 24'sd655;
   localparam logic signed [GAIN_BITS-1:0] GAIN_I_RESET  = 24'sd0;
   localparam logic signed [GAIN_BITS-1:0] GAIN_D_RESET  = 24'sd0;
   localparam logic        [PWM_BITS-1:0]  MIN_PWM_RESET = 8'd0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GAIN_P  = 2'd0,
      REG_GAIN_I  = 2'd1,
      REG_GAIN_D  = 2'd2,
      REG_MIN_PWM = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SPEED_BITS-1:0] target_speed;
      logic signed [SPEED_BITS-1:0] measured_speed;
   } req_payload_type;

   typedef struct packed {
      logic [PWM_BITS-1:0] pwm_level;
      logic                forward;
   } rsp_payload_type;

endpackage

[rtl/motor_speed_pid_pwm.sv]
// ----------------------------------------------------------------------------
// motor_speed_pid_pwm: PID speed controller with derivative on measurement
// Registered in order: input, products, adjustment, response. Throughput: one
// item per cycle unless the response stalls; the duty and integral loops each
// close within a single stage, so back-to-back items never wait on each other.
// Reset (synchronous, active high) empties the pipeline, loads the register
// defaults, clears the integral, previous speed and duty, and sets forward.
// ----------------------------------------------------------------------------
module motor_speed_pid_pwm #(
   parameter int GAIN_FRACTION_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Request channel: one item per control tick.
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  msp_pkg::req_payload_type                req_payload,
   // Response channel: new PWM level and direction.
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output msp_pkg::rsp_payload_type                rsp_payload,
   // Register write port.
   input  logic                                    csr_wr_en,
   input  logic [msp_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [msp_pkg::GAIN_BITS-1:0]           csr_wr_data
);

   // Widths. The product of a gain and a speed difference is PW bits; the
   // accumulator holds P + I - D without overflow, with two spare bits.
   localparam int SB   = msp_pkg::SPEED_BITS;
   localparam int GW   = msp_pkg::GAIN_BITS;
   localparam int IW   = msp_pkg::INTEG_BITS;
   localparam int PB   = msp_pkg::PWM_BITS;
   localparam int PW   = GW + SB;
   localparam int MAXW = (PW > IW) ? PW : IW;
   localparam int ACCW = MAXW + 2;
   // The adjustment is saturated to a range that still drives any duty to
   // either clamp limit, so the final add stays narrow.
   localparam int ADJW = PB + 2;
   localparam int SUMW = PB + 3;

   // Magnitude of a signed speed, saturating the most negative value.
   function automatic logic [SB-2:0] speed_mag(input logic signed [SB-1:0] v);
      logic [SB-1:0] m;
      m = v[SB-1] ? -v : v;
      return m[SB-1] ? {(SB-1){1'b1}} : m[SB-2:0];
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic signed [GW-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic        [PB-1:0] min_pwm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff  <= msp_pkg::GAIN_P_RESET;
         gain_i_ff  <= msp_pkg::GAIN_I_RESET;
         gain_d_ff  <= msp_pkg::GAIN_D_RESET;
         min_pwm_ff <= msp_pkg::MIN_PWM_RESET;
      end else if (csr_wr_en) begin
         unique case (msp_pkg::csr_index_type'(csr_index))
            msp_pkg::REG_GAIN_P:  gain_p_ff  <= $signed(csr_wr_data);
            msp_pkg::REG_GAIN_I:  gain_i_ff  <= $signed(csr_wr_data);
            msp_pkg::REG_GAIN_D:  gain_d_ff  <= $signed(csr_wr_data);
            msp_pkg::REG_MIN_PWM: min_pwm_ff <= csr_wr_data[PB-1:0];
            default:              ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control. Each stage loads when it is empty or when its
   // item moves on, so bubbles close up while the response is stalled.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic ready1, ready2, ready3, out_take;

   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign ready3    = !s3_valid_ff || out_take;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_ready = ready1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1)   s1_valid_ff  <= req_valid;
         if (ready2)   s2_valid_ff  <= s1_valid_ff;
         if (ready3)   s3_valid_ff  <= s2_valid_ff;
         if (out_take) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: input register.
   // ------------------------------------------------------------------------
   msp_pkg::req_payload_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (ready1) s1_req_ff <= req_payload;
   end

   // ------------------------------------------------------------------------
   // Stage 1 to 2: magnitudes, direction, error and the three products.
   // The previous measurement and the direction advance with each item.
   // ------------------------------------------------------------------------
   logic [SB-2:0]        prev_speed_ff, sp_mag, ms_mag;
   logic                 dir_ff, dir_in;
   logic signed [SB-1:0] err, dmeas;
   logic signed [PW-1:0] pe_in, ie_in, de_in;

   assign sp_mag = speed_mag(s1_req_ff.target_speed);
   assign ms_mag = speed_mag(s1_req_ff.measured_speed);
   assign err    = $signed({1'b0, sp_mag}) - $signed({1'b0, ms_mag});
   assign dmeas  = $signed({1'b0, ms_mag}) - $signed({1'b0, prev_speed_ff});
   assign pe_in  = gain_p_ff * err;
   assign ie_in  = gain_i_ff * err;
   assign de_in  = gain_d_ff * dmeas;

   // A zero target keeps the direction it had.
   always_comb begin
      priority if (s1_req_ff.target_speed[SB-1])  dir_in = 1'b0;
      else if (|s1_req_ff.target_speed)           dir_in = 1'b1;
      else                                        dir_in = dir_ff;
   end

   logic signed [PW-1:0] s2_pe_ff, s2_ie_ff, s2_de_ff;
   logic                 s2_fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_speed_ff <= '0;
         dir_ff        <= 1'b1;
      end else if (s1_valid_ff && ready2) begin
         prev_speed_ff <= ms_mag;
         dir_ff        <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         s2_pe_ff  <= pe_in;
         s2_ie_ff  <= ie_in;
         s2_de_ff  <= de_in;
         s2_fwd_ff <= dir_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2 to 3: saturating integral, P + I - D, truncation toward zero.
   // ------------------------------------------------------------------------
   logic signed [IW-1:0]   integ_ff, integ_in;
   logic signed [ACCW-1:0] isum, total, tq, adj_full;
   logic [ACCW-IW:0]       isum_hi;
   logic [ACCW-ADJW:0]     adj_hi;
   logic signed [ADJW-1:0] adj_in;

   assign isum    = ACCW'(integ_ff) + ACCW'(s2_ie_ff);
   assign isum_hi = isum[ACCW-1:IW-1];
   assign integ_in = ((&isum_hi) || !(|isum_hi)) ? isum[IW-1:0]
                                                : {isum[ACCW-1], {(IW-1){~isum[ACCW-1]}}};

   assign total = ACCW'(s2_pe_ff) + ACCW'(integ_in) - ACCW'(s2_de_ff);
   assign tq    = total >>> GAIN_FRACTION_BITS;
   // A negative value with a nonzero fraction rounds up toward zero.
   assign adj_full = tq + ACCW'(total[ACCW-1] && (|total[GAIN_FRACTION_BITS-1:0]));
   assign adj_hi   = adj_full[ACCW-1:ADJW-1];
   assign adj_in   = ((&adj_hi) || !(|adj_hi)) ? adj_full[ADJW-1:0]
                                              : {adj_full[ACCW-1], {(ADJW-1){~adj_full[ACCW-1]}}};

   logic signed [ADJW-1:0] s3_adj_ff;
   logic                   s3_fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (s2_valid_ff && ready3) begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         s3_adj_ff <= adj_in;
         s3_fwd_ff <= s2_fwd_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3 to output: add the adjustment to the stored duty and clamp it
   // to [min_pwm, 255]. The response register and the duty load together.
   // ------------------------------------------------------------------------
   logic [PB-1:0]          duty_ff, duty_in;
   logic signed [SUMW-1:0] pwm_sum;
   msp_pkg::rsp_payload_type rsp_payload_ff;

   assign pwm_sum = $signed({{(SUMW-PB){1'b0}}, duty_ff}) + SUMW'(s3_adj_ff);

   always_comb begin
      priority if (pwm_sum < $signed({{(SUMW-PB){1'b0}}, min_pwm_ff}))
         duty_in = min_pwm_ff;
      else if (pwm_sum > SUMW'(msp_pkg::PWM_MAX))
         duty_in = PB'(msp_pkg::PWM_MAX);
      else
         duty_in = pwm_sum[PB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
      end else if (s3_valid_ff && out_take) begin
         duty_ff <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_payload_ff.pwm_level <= duty_in;
         rsp_payload_ff.forward   <= s3_fwd_ff;
      end
   end

   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // A pending response always carries the stored duty level.
   a_rsp_matches_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.pwm_level == duty_ff))
      else $error("pending response differs from stored duty");

   // The request side only stalls when every stage holds an item.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff))
      else $error("request stalled with an empty stage");

   // A blocked stage 3 item keeps its adjustment.
   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !ready3) |=> (s3_valid_ff && $stable(s3_adj_ff)))
      else $error("blocked stage 3 item changed");

endmodule
